### sv/assert_macros.svh
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is held.
`define QTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define QTE_ASSERT_IMP(lbl, pre, post, msg) \
  `QTE_ASSERT(lbl, (pre) |-> (post), msg)

`endif

### sv/qte_pkg.sv
// Shared widths, constants, operand bundle and CORDIC angle table.
`default_nettype none
package qte_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int NSTEP = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

  localparam int QW   = 16;  // quaternion component
  localparam int PW   = 32;  // product of two components
  localparam int OPW  = 34;  // atan2 operand
  localparam int SW   = 32;  // clamped sine term and root
  localparam int RW   = 63;  // square root radicand
  localparam int CW   = 52;  // CORDIC vector
  localparam int AW   = 35;  // CORDIC angle accumulator, degrees * 2^24
  localparam int OUTW = 16;  // angle result
  localparam int YW   = 15;  // pitch angle field
  localparam int SQRT_STAGES = (RW + 1) / 2;

  localparam logic signed [OPW-1:0]  ONE_Q30  = 34'sd1073741824;
  localparam logic signed [AW-1:0]   DEG180   = 35'sd3019898880;
  localparam logic signed [OUTW-1:0] XZ_LIMIT = 16'sd23040;
  localparam logic signed [OUTW-1:0] Y_LIMIT  = 16'sd11520;

  typedef struct packed {
    logic signed [OPW-1:0] yaw_y;
    logic signed [OPW-1:0] yaw_x;
    logic signed [OPW-1:0] roll_y;
    logic signed [OPW-1:0] roll_x;
    logic signed [SW-1:0]  pitch_s;
    logic                  sat;
  } qte_ops_t;

  // atan(2^-i) in degrees times 2^24, rounded.
  function automatic logic signed [AW-1:0] step_angle(input int unsigned idx);
    logic signed [AW-1:0] a;
    unique case (idx)
      0:  a = 35'sd754974720;
      1:  a = 35'sd445687602;
      2:  a = 35'sd235489088;
      3:  a = 35'sd119537938;
      4:  a = 35'sd60000934;
      5:  a = 35'sd30029717;
      6:  a = 35'sd15018523;
      7:  a = 35'sd7509720;
      8:  a = 35'sd3754917;
      9:  a = 35'sd1877466;
      10: a = 35'sd938734;
      11: a = 35'sd469367;
      12: a = 35'sd234684;
      13: a = 35'sd117342;
      14: a = 35'sd58671;
      15: a = 35'sd29335;
      16: a = 35'sd14668;
      17: a = 35'sd7334;
      18: a = 35'sd3667;
      19: a = 35'sd1833;
      20: a = 35'sd917;
      21: a = 35'sd458;
      22: a = 35'sd229;
      23: a = 35'sd115;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

### sv/qte_quat_if.sv
// Input channel: one quaternion per transfer.
`default_nettype none
interface qte_quat_if import qte_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [QW-1:0] quat_w;
  logic signed [QW-1:0] quat_x;
  logic signed [QW-1:0] quat_y;
  logic signed [QW-1:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface
`default_nettype wire

### sv/qte_euler_if.sv
// Output channel: one set of Euler angles per transfer.
`default_nettype none
interface qte_euler_if import qte_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [OUTW-1:0] angle_about_x;
  logic signed [YW-1:0]   angle_about_y;
  logic signed [OUTW-1:0] angle_about_z;
  logic                   pitch_saturated;

  modport source (output valid, angle_about_x, angle_about_y, angle_about_z,
                  pitch_saturated, input ready);
  modport sink   (input valid, angle_about_x, angle_about_y, angle_about_z,
                  pitch_saturated, output ready);
endinterface
`default_nettype wire

### sv/qte_front.sv
// Front end: component products, atan2 operands, sine clamp and radicand.
`default_nettype none
module qte_front import qte_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [QW-1:0] quat_w_i,
  input  logic signed [QW-1:0] quat_x_i,
  input  logic signed [QW-1:0] quat_y_i,
  input  logic signed [QW-1:0] quat_z_i,
  output logic                 valid_o,
  output qte_ops_t             ops_o,
  output logic [RW-1:0]        rad_o
);

  logic vld1_q, vld2_q, vld3_q;
  logic signed [PW-1:0] ww_q, xx_q, yy_q, zz_q, xy_q, zw_q, yz_q, xw_q, yw_q, xz_q;
  qte_ops_t ops2_d, ops2_q, ops3_q;
  logic signed [OPW-1:0] s_raw;
  logic signed [2*SW-1:0] sq;
  logic [RW-1:0] rad_d, rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_comb begin
    ops2_d.yaw_y  = (OPW'(xy_q) + OPW'(zw_q)) <<< 1;
    ops2_d.yaw_x  = OPW'(ww_q) + OPW'(xx_q) - OPW'(yy_q) - OPW'(zz_q);
    ops2_d.roll_y = (OPW'(yz_q) + OPW'(xw_q)) <<< 1;
    ops2_d.roll_x = OPW'(ww_q) - OPW'(xx_q) - OPW'(yy_q) + OPW'(zz_q);
    s_raw = (OPW'(yw_q) - OPW'(xz_q)) <<< 1;
    // Non-unit quaternions can push the sine past one; clamp it.
    if (s_raw > ONE_Q30) begin
      ops2_d.pitch_s = SW'(ONE_Q30);
      ops2_d.sat     = 1'b1;
    end else if (s_raw < -ONE_Q30) begin
      ops2_d.pitch_s = SW'(-ONE_Q30);
      ops2_d.sat     = 1'b1;
    end else begin
      ops2_d.pitch_s = SW'(s_raw);
      ops2_d.sat     = 1'b0;
    end
  end

  always_comb begin
    sq    = ops2_q.pitch_s * ops2_q.pitch_s;
    rad_d = (RW'(1) << 60) - RW'($unsigned(sq));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ww_q   <= quat_w_i * quat_w_i;
      xx_q   <= quat_x_i * quat_x_i;
      yy_q   <= quat_y_i * quat_y_i;
      zz_q   <= quat_z_i * quat_z_i;
      xy_q   <= quat_x_i * quat_y_i;
      zw_q   <= quat_z_i * quat_w_i;
      yz_q   <= quat_y_i * quat_z_i;
      xw_q   <= quat_x_i * quat_w_i;
      yw_q   <= quat_y_i * quat_w_i;
      xz_q   <= quat_x_i * quat_z_i;
      ops2_q <= ops2_d;
      ops3_q <= ops2_q;
      rad_q  <= rad_d;
    end
  end

  assign valid_o = vld3_q;
  assign ops_o   = ops3_q;
  assign rad_o   = rad_q;

endmodule
`default_nettype wire

### sv/qte_isqrt.sv
// Pipelined integer square root, one result bit per stage, operands ride along.
`default_nettype none
module qte_isqrt import qte_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [RW-1:0] rad_i,
  input  qte_ops_t      ops_i,
  output logic          valid_o,
  output qte_ops_t      ops_o,
  output logic [SW-1:0] root_o
);

  logic [RW-1:0] v_q [SQRT_STAGES];
  logic [RW-1:0] r_q [SQRT_STAGES];
  qte_ops_t      o_q [SQRT_STAGES];
  logic          vld_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [RW-1:0] v_in, r_in, bitv, trial, v_d, r_d;
    qte_ops_t o_in;
    logic vld_in;

    if (k == 0) begin : g_first
      assign v_in   = rad_i;
      assign r_in   = '0;
      assign o_in   = ops_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign r_in   = r_q[k-1];
      assign o_in   = o_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    always_comb begin
      bitv  = RW'(1) << (RW - 1 - 2 * k);
      trial = r_in + bitv;
      if (v_in >= trial) begin
        v_d = v_in - trial;
        r_d = (r_in >> 1) + bitv;
      end else begin
        v_d = v_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k] <= v_d;
        r_q[k] <= r_d;
        o_q[k] <= o_in;
      end
    end
  end

  assign valid_o = vld_q[SQRT_STAGES-1];
  assign ops_o   = o_q[SQRT_STAGES-1];
  assign root_o  = r_q[SQRT_STAGES-1][SW-1:0];

endmodule
`default_nettype wire

### sv/qte_cordic.sv
// Pipelined vectoring CORDIC atan2 with half-plane fold, rounding and clamp.
`default_nettype none
module qte_cordic import qte_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [OPW-1:0]  y_i,
  input  logic signed [OPW-1:0]  x_i,
  input  logic signed [OUTW-1:0] limit_i,
  output logic                   valid_o,
  output logic signed [OUTW-1:0] angle_o
);

  localparam int RQW = AW + 1 - 17;

  logic signed [CW-1:0]   x_q [NSTEP+1];
  logic signed [CW-1:0]   y_q [NSTEP+1];
  logic signed [AW-1:0]   a_q [NSTEP+1];
  logic                   z_q [NSTEP+1];
  logic                   vld_q [NSTEP+1];
  logic signed [OUTW-1:0] lim_q [NSTEP+1];

  logic signed [CW-1:0]   xe, ye, x0, y0;
  logic signed [AW-1:0]   a0;
  logic                   neg;

  logic signed [AW:0]     rs;
  logic signed [RQW-1:0]  rq, lim, clamped;
  logic signed [OUTW-1:0] ang_d, ang_q;
  logic                   out_vld_q;

  // Fold the left half plane onto the right, starting the angle at +-180.
  always_comb begin
    xe  = CW'(x_i);
    ye  = CW'(y_i);
    neg = x_i[OPW-1];
    x0  = (neg ? -xe : xe) <<< 16;
    y0  = (neg ? -ye : ye) <<< 16;
    if (neg) begin
      a0 = y_i[OPW-1] ? -DEG180 : DEG180;
    end else begin
      a0 = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= x0;
      y_q[0]   <= y0;
      a_q[0]   <= a0;
      z_q[0]   <= (x_i == '0) && (y_i == '0);
      lim_q[0] <= limit_i;
    end
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    logic signed [CW-1:0] x_d, y_d;
    logic signed [AW-1:0] a_d;

    always_comb begin
      if (!y_q[i][CW-1]) begin
        x_d = x_q[i] + (y_q[i] >>> i);
        y_d = y_q[i] - (x_q[i] >>> i);
        a_d = a_q[i] + step_angle(i);
      end else begin
        x_d = x_q[i] - (y_q[i] >>> i);
        y_d = y_q[i] + (x_q[i] >>> i);
        a_d = a_q[i] - step_angle(i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]   <= x_d;
        y_q[i+1]   <= y_d;
        a_q[i+1]   <= a_d;
        z_q[i+1]   <= z_q[i];
        lim_q[i+1] <= lim_q[i];
      end
    end
  end

  // Round to 1/128 degree, then clamp to the field range.
  always_comb begin
    rs  = (AW+1)'(a_q[NSTEP]) + (AW+1)'(65536);
    rq  = rs[AW:17];
    lim = RQW'(lim_q[NSTEP]);
    if (rq > lim) begin
      clamped = lim;
    end else if (rq < -lim) begin
      clamped = -lim;
    end else begin
      clamped = rq;
    end
    ang_d = z_q[NSTEP] ? '0 : OUTW'(clamped);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[NSTEP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= ang_d;
    end
  end

  assign valid_o = out_vld_q;
  assign angle_o = ang_q;

endmodule
`default_nettype wire

### sv/quaternion_to_euler_angles.sv
// Quaternion to Z-Y-X Euler angle converter, top level.
//
// Takes one Q1.15 quaternion per cycle and returns yaw (about z), roll
// (about x) and pitch (about y) in degrees times 128. The pipeline accepts a
// new quaternion every cycle unless a blocked output result freezes it.
// The depth is set by the pitch path: three front stages for the component
// products, the sine clamp and the radicand, a 32-stage square root that
// yields the cosine one bit per stage, then the CORDIC pipeline with one stage
// for the half-plane fold, one per rotation step and one for rounding, and
// finally the output register. Yaw and roll operands travel alongside the
// square root so all three angles leave together. A stall on the output
// freezes the pipeline only when the last stage holds a result; empty slots
// keep moving, so transfers are still accepted while a finished result waits.
// A pitch sine beyond magnitude one is clamped and flagged in
// pitch_saturated. A zero-length atan2 operand pair gives an angle of zero.
`default_nettype none
module quaternion_to_euler_angles import qte_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  qte_quat_if.sink           quat_i,
  qte_euler_if.source        euler_o
);

`include "assert_macros.svh"

  logic                   en;
  logic                   fr_vld, sq_vld;
  qte_ops_t               fr_ops, sq_ops;
  logic [RW-1:0]          fr_rad;
  logic [SW-1:0]          root;
  logic signed [OPW-1:0]  pitch_y, pitch_x;
  logic                   yaw_vld, roll_vld, pitch_vld;
  logic signed [OUTW-1:0] yaw_ang, roll_ang, pitch_ang;
  logic [NSTEP+1:0]       sat_q;

  logic                   out_vld_q;
  logic signed [OUTW-1:0] ax_q, az_q;
  logic signed [YW-1:0]   ay_q;
  logic                   sat_out_q;

  // The whole pipeline moves unless a finished result is blocked at the end.
  assign en           = !yaw_vld || !out_vld_q || euler_o.ready;
  assign quat_i.ready = en;

  qte_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (quat_i.valid),
    .quat_w_i (quat_i.quat_w),
    .quat_x_i (quat_i.quat_x),
    .quat_y_i (quat_i.quat_y),
    .quat_z_i (quat_i.quat_z),
    .valid_o  (fr_vld),
    .ops_o    (fr_ops),
    .rad_o    (fr_rad)
  );

  qte_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_vld),
    .rad_i   (fr_rad),
    .ops_i   (fr_ops),
    .valid_o (sq_vld),
    .ops_o   (sq_ops),
    .root_o  (root)
  );

  // Pitch is asin(s), computed as atan2(s, sqrt(1 - s^2)).
  assign pitch_y = OPW'(sq_ops.pitch_s);
  assign pitch_x = OPW'({1'b0, root});

  qte_cordic u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .y_i     (sq_ops.yaw_y),
    .x_i     (sq_ops.yaw_x),
    .limit_i (XZ_LIMIT),
    .valid_o (yaw_vld),
    .angle_o (yaw_ang)
  );

  qte_cordic u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .y_i     (sq_ops.roll_y),
    .x_i     (sq_ops.roll_x),
    .limit_i (XZ_LIMIT),
    .valid_o (roll_vld),
    .angle_o (roll_ang)
  );

  qte_cordic u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .y_i     (pitch_y),
    .x_i     (pitch_x),
    .limit_i (Y_LIMIT),
    .valid_o (pitch_vld),
    .angle_o (pitch_ang)
  );

  // The saturation flag follows the CORDIC latency in a plain delay line.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sat_q <= {sat_q[NSTEP:0], sq_ops.sat};
    end
  end

  // Output register: loads when the last stage delivers, clears on transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en && yaw_vld) begin
      out_vld_q <= 1'b1;
    end else if (euler_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && yaw_vld) begin
      ax_q      <= roll_ang;
      ay_q      <= pitch_ang[YW-1:0];
      az_q      <= yaw_ang;
      sat_out_q <= sat_q[NSTEP+1];
    end
  end

  assign euler_o.valid           = out_vld_q;
  assign euler_o.angle_about_x   = ax_q;
  assign euler_o.angle_about_y   = ay_q;
  assign euler_o.angle_about_z   = az_q;
  assign euler_o.pitch_saturated = sat_out_q;

  `QTE_ASSERT(a_lanes_in_step, (yaw_vld == roll_vld) && (yaw_vld == pitch_vld), "CORDIC lanes out of step")
  `QTE_ASSERT_IMP(a_roll_range, out_vld_q, (ax_q <= XZ_LIMIT) && (ax_q >= -XZ_LIMIT), "roll out of range")
  `QTE_ASSERT_IMP(a_pitch_range, out_vld_q, (OUTW'(ay_q) <= Y_LIMIT) && (OUTW'(ay_q) >= -Y_LIMIT), "pitch out of range")

endmodule
`default_nettype wire

### sim/tb_quaternion_to_euler_angles.sv
// Self-checking testbench for the quaternion to Euler angle converter.
`default_nettype none
module tb_quaternion_to_euler_angles;
  import qte_pkg::*;

  // Expected angles for one quaternion, at the widths of the result channel.
  typedef struct packed {
    logic signed [OUTW-1:0] roll;
    logic signed [YW-1:0]   pitch;
    logic signed [OUTW-1:0] yaw;
    logic                   clamped;
  } angles_t;

  logic clk_i;
  logic rst_ni;

  qte_quat_if  quat_ch ();
  qte_euler_if euler_ch ();

  quaternion_to_euler_angles dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .quat_i  (quat_ch.sink),
    .euler_o (euler_ch.source)
  );

  angles_t angles_due[$];
  int      errors;

  // Chance, in percent, that the sender skips a cycle or the receiver stalls.
  int send_gap_pct;
  int recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // atan(2^-i) in degrees times 2^24, the rotation angles of the CORDIC.
  function automatic longint rot_angle(int i);
    longint tbl [24] = '{754974720, 445687602, 235489088, 119537938, 60000934,
      30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
      117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
    return tbl[i];
  endfunction

  // Integer square root by the bit-pair method; the argument is non-negative.
  function automatic longint int_sqrt(longint v);
    longint root;
    longint bitv;
    root = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > v) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >>> 1) + bitv;
      end else begin
        root = root >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return root;
  endfunction

  // Vectoring CORDIC atan2 in degrees times 128, clamped to +-lim.
  // Operands stay below 2^34, so after the 2^16 prescale they fit in 64 bits.
  function automatic longint vec_atan2(longint yv, longint xv, longint lim);
    longint acc;
    longint xs;
    longint ys;
    longint res;
    int     steps;
    acc = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      acc = (yv >= 0) ? (64'sd180 <<< 24) : -(64'sd180 <<< 24);
      xv = -xv;
      yv = -yv;
    end
    xv = xv * 65536;
    yv = yv * 65536;
    steps = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    for (int i = 0; i < steps; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv >= 0) begin
        xv = xv + ys;
        yv = yv - xs;
        acc = acc + rot_angle(i);
      end else begin
        xv = xv - ys;
        yv = yv + xs;
        acc = acc - rot_angle(i);
      end
    end
    res = (acc + 65536) >>> 17;
    if (res > lim) res = lim;
    if (res < -lim) res = -lim;
    return res;
  endfunction

  // Z-Y-X Euler angles of one quaternion.
  function automatic angles_t euler_of(logic signed [QW-1:0] qw,
                                       logic signed [QW-1:0] qx,
                                       logic signed [QW-1:0] qy,
                                       logic signed [QW-1:0] qz);
    longint  w, x, y, z;
    longint  sn, cs;
    longint  one;
    angles_t r;
    w = qw; x = qx; y = qy; z = qz;
    one = 64'sd1 <<< 30;
    r.yaw  = OUTW'(vec_atan2(2 * (x * y + z * w), w*w + x*x - y*y - z*z, 23040));
    r.roll = OUTW'(vec_atan2(2 * (y * z + x * w), w*w - x*x - y*y + z*z, 23040));
    sn = 2 * (y * w - x * z);
    r.clamped = 1'b0;
    // A quaternion that is not normalized can push the sine past one.
    if (sn > one) begin
      sn = one;
      r.clamped = 1'b1;
    end else if (sn < -one) begin
      sn = -one;
      r.clamped = 1'b1;
    end
    cs = int_sqrt((64'sd1 <<< 60) - sn * sn);
    r.pitch = YW'(vec_atan2(sn, cs, 11520));
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d (%0d pending)",
             what, got, want, angles_due.size());
    errors++;
  endtask

  // Sends one quaternion; the transfer completes at the edge where ready is
  // high. The expectation is queued at that edge, before the result can come.
  // Valid stays high afterwards so that items can follow back to back; the
  // caller drops it before waiting.
  task automatic send_quat(logic [QW-1:0] w, logic [QW-1:0] x,
                           logic [QW-1:0] y, logic [QW-1:0] z);
    while ($urandom_range(99) < send_gap_pct) begin
      quat_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    quat_ch.valid  <= 1'b1;
    quat_ch.quat_w <= w;
    quat_ch.quat_x <= x;
    quat_ch.quat_y <= y;
    quat_ch.quat_z <= z;
    do @(posedge clk_i); while (!quat_ch.ready);
    angles_due.insert(angles_due.size(), euler_of(w, x, y, z));
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk_i) begin
    if (rst_ni && euler_ch.valid && euler_ch.ready) begin
      if (angles_due.size() == 0) begin
        $display("result transfer with nothing pending");
        errors++;
      end else begin
        angles_t e;
        e = angles_due.pop_front();
        if (euler_ch.angle_about_x !== e.roll)
          report_mismatch("angle_about_x", euler_ch.angle_about_x, e.roll);
        if (euler_ch.angle_about_y !== e.pitch)
          report_mismatch("angle_about_y", euler_ch.angle_about_y, e.pitch);
        if (euler_ch.angle_about_z !== e.yaw)
          report_mismatch("angle_about_z", euler_ch.angle_about_z, e.yaw);
        if (euler_ch.pitch_saturated !== e.clamped)
          report_mismatch("pitch_saturated", euler_ch.pitch_saturated, e.clamped);
      end
    end
    euler_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic wait_drained();
    quat_ch.valid <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk_i);
  endtask

  // Extremes of each component, zero-length operand pairs, clamped sines.
  task automatic test_directed();
    logic [QW-1:0] ext [4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    send_quat(0, 0, 0, 0);
    send_quat(16'h7fff, 0, 0, 0);
    send_quat(16'h8000, 0, 0, 0);
    send_quat(0, 16'h7fff, 0, 0);
    send_quat(0, 0, 16'h7fff, 0);
    send_quat(0, 0, 0, 16'h8000);
    // Sine far past one in both directions.
    send_quat(16'h7fff, 0, 16'h7fff, 0);
    send_quat(16'h7fff, 0, 16'h8000, 0);
    send_quat(16'h5a82, 0, 16'h5a82, 0);
    send_quat(16'h5a82, 16'h5a82, 0, 0);
    send_quat(16'h5a82, 0, 0, 16'ha57e);
    for (int i = 0; i < 12; i++)
      send_quat(ext[$urandom_range(3)], ext[$urandom_range(3)],
                ext[$urandom_range(3)], ext[$urandom_range(3)]);
  endtask

  // Roughly unit quaternions, with a share of raw random components.
  task automatic test_random(int n);
    int          a, b, c, d;
    longint      mag;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(3) == 0) begin
        send_quat(QW'($urandom), QW'($urandom), QW'($urandom), QW'($urandom));
      end else begin
        a = $signed($urandom_range(65535)) - 32768;
        b = $signed($urandom_range(65535)) - 32768;
        c = $signed($urandom_range(65535)) - 32768;
        d = $signed($urandom_range(65535)) - 32768;
        mag = int_sqrt(longint'(a)*a + longint'(b)*b + longint'(c)*c + longint'(d)*d);
        if (mag == 0) mag = 1;
        send_quat(QW'(32767 * a / mag), QW'(32767 * b / mag),
                  QW'(32767 * c / mag), QW'(32767 * d / mag));
      end
    end
  endtask

  // The sender holds off until the pipeline has fully drained.
  task automatic test_pause_until_drained();
    test_random(20);
    wait_drained();
    test_random(20);
  endtask

  initial begin
    errors = 0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    quat_ch.valid  = 1'b0;
    quat_ch.quat_w = '0;
    quat_ch.quat_x = '0;
    quat_ch.quat_y = '0;
    quat_ch.quat_z = '0;
    euler_ch.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(320);
    send_gap_pct = 49;
    test_random(320);
    send_gap_pct = 0;
    recv_stall_pct = 49;
    test_random(320);
    send_gap_pct = 25;
    recv_stall_pct = 25;
    test_pause_until_drained();
    test_random(320);

    wait_drained();
    repeat (3 + 32 + CORDIC_STEPS + 10) @(posedge clk_i);
    if (errors == 0)
      $display("** quaternion_to_euler_angles: PASSED **");
    else
      $display("** quaternion_to_euler_angles: FAILED **");
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("timeout");
    $display("** quaternion_to_euler_angles: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
+incdir+sv
sv/qte_pkg.sv
sv/qte_quat_if.sv
sv/qte_euler_if.sv
sv/qte_front.sv
sv/qte_isqrt.sv
sv/qte_cordic.sv
sv/quaternion_to_euler_angles.sv
sim/tb_quaternion_to_euler_angles.sv
